// File: rtl/core/pidaw_pkg.sv
package pidaw_pkg;

  localparam int OUT_MIN_Q_DEF = 0;
  localparam int OUT_MAX_Q_DEF = 65536;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W      = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DER_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_THRESH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd7;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_PRESET = 2'd2;

  localparam int MODE_NORM    = 0;
  localparam int MODE_ON_MEAS = 1;
  localparam int MODE_AW      = 2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_NORM_MUL,
    ST_NORM_RES,
    ST_P_MUL,
    ST_P_RES,
    ST_I1_MUL,
    ST_I1_RES,
    ST_I2_MUL,
    ST_I2_RES,
    ST_D_SUB,
    ST_DIV,
    ST_D_QUO,
    ST_DN_MUL,
    ST_DN_RES,
    ST_DG_MUL,
    ST_DG_RES,
    ST_SUM,
    ST_DONE
  } pidaw_state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] measured;
    logic signed [31:0] target;
    logic [30:0]        step_time;
    logic signed [31:0] integral_preset;
  } pidaw_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] control_output;
    logic             integrating;
    logic             held;
  } pidaw_out_t;

endpackage

// File: rtl/core/pid_controller_antiwindup.sv
// PID controller with integral separation and anti-windup, signed Q16.16.
//
// Input channel in_valid/in_stall/in_data carries one item: an update step,
// a state clear or an integral preset. The result channel out_valid/
// out_stall/out_data returns exactly one result per item, in order.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// by the user only while the block is idle; the block does not enforce it.
//
// Clear, preset, unused kinds and zero step time go from ST_START straight
// to ST_DONE. An update runs through the normalization, proportional,
// integral and derivative states; normalization is skipped when off and
// integration when the separation test fails. The restoring divider for
// the derivative rate, one quotient bit per cycle, takes most of an update,
// and one shared 32x32 multiplier runs up to six products in turn. One item
// is processed at a time; in_stall is high from acceptance until the result
// is loaded into the output register.
//
// Reset clears all controller state and restores the register defaults.
// When the receiver stalls, the result holds in the output register and a
// finished item waits in its last state until the register frees up.
module pid_controller_antiwindup #(
  parameter int OUT_MIN_Q = pidaw_pkg::OUT_MIN_Q_DEF,
  parameter int OUT_MAX_Q = pidaw_pkg::OUT_MAX_Q_DEF,
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pidaw_pkg::pidaw_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pidaw_pkg::pidaw_out_t               out_data,
  input  logic                                cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
  localparam logic [30:0] ONE_Q = 31'(1) << FRAC_BITS;
  localparam logic signed [33:0] OUT_MIN_S = 34'(OUT_MIN_Q);
  localparam logic signed [33:0] OUT_MAX_S = 34'(OUT_MAX_Q);
  localparam logic signed [31:0] OUT_MIN_32 = 32'(OUT_MIN_Q);
  localparam logic signed [31:0] OUT_MAX_32 = 32'(OUT_MAX_Q);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < 64'shFFFFFFFF80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [32:0] v33;
    logic signed [32:0] l33;
    logic signed [31:0] r;
    v33 = 33'(v);
    l33 = $signed({2'b00, lim});
    if (v33 > l33) r = l33[31:0];
    else if (v33 < -l33) r = 32'(-l33);
    else r = v;
    return r;
  endfunction

  // configuration
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0]        err_scale_r, der_scale_r, sep_thresh_r, int_limit_r;
  logic [2:0]         mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      err_scale_r  <= 31'd65536;
      der_scale_r  <= 31'd65536;
      sep_thresh_r <= 31'h7FFFFFFF;
      int_limit_r  <= '0;
      mode_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidaw_pkg::CFG_GAIN_P:     gain_p_r     <= $signed(cfg_data);
        pidaw_pkg::CFG_GAIN_I:     gain_i_r     <= $signed(cfg_data);
        pidaw_pkg::CFG_GAIN_D:     gain_d_r     <= $signed(cfg_data);
        pidaw_pkg::CFG_ERR_SCALE:  err_scale_r  <= cfg_data[30:0];
        pidaw_pkg::CFG_DER_SCALE:  der_scale_r  <= cfg_data[30:0];
        pidaw_pkg::CFG_SEP_THRESH: sep_thresh_r <= cfg_data[30:0];
        pidaw_pkg::CFG_INT_LIMIT:  int_limit_r  <= cfg_data[30:0];
        pidaw_pkg::CFG_MODE:       mode_r       <= cfg_data[2:0];
      endcase
    end
  end

  wire norm    = mode_r[pidaw_pkg::MODE_NORM];
  wire on_meas = mode_r[pidaw_pkg::MODE_ON_MEAS];
  wire aw_en   = mode_r[pidaw_pkg::MODE_AW];

  pidaw_pkg::pidaw_state_t state_r, state_nxt;
  pidaw_pkg::pidaw_in_t    item_r;

  logic signed [31:0] raw_r, err_r, p_r, der_r, d_r, gi_err_r;
  logic signed [31:0] isum_r, isum_nxt, pm_r, pm_nxt, pe_r, pe_nxt;
  logic [16:0]        last_r, last_nxt;
  logic               integ_r, held_r, held_nxt, flag_nxt;
  logic               integ_nxt;
  logic [DW-1:0]      div_q_r;
  logic [30:0]        div_rem_r;
  logic [CW-1:0]      div_cnt_r;
  logic               div_neg_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] mul_a, mul_b;
  logic               out_valid_r;
  pidaw_pkg::pidaw_out_t out_data_r;

  wire in_fire  = in_valid && !in_stall;
  wire out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != pidaw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pidaw_pkg::ST_IDLE:     if (in_fire) state_nxt = pidaw_pkg::ST_START;
      pidaw_pkg::ST_START: begin
        if (item_r.kind == pidaw_pkg::KIND_UPDATE && item_r.step_time != '0)
          state_nxt = norm ? pidaw_pkg::ST_NORM_MUL : pidaw_pkg::ST_P_MUL;
        else
          state_nxt = pidaw_pkg::ST_DONE;
      end
      pidaw_pkg::ST_NORM_MUL: state_nxt = pidaw_pkg::ST_NORM_RES;
      pidaw_pkg::ST_NORM_RES: state_nxt = pidaw_pkg::ST_P_MUL;
      pidaw_pkg::ST_P_MUL:    state_nxt = pidaw_pkg::ST_P_RES;
      pidaw_pkg::ST_P_RES:
        state_nxt = integ_nxt ? pidaw_pkg::ST_I1_MUL : pidaw_pkg::ST_D_SUB;
      pidaw_pkg::ST_I1_MUL:   state_nxt = pidaw_pkg::ST_I1_RES;
      pidaw_pkg::ST_I1_RES:   state_nxt = pidaw_pkg::ST_I2_MUL;
      pidaw_pkg::ST_I2_MUL:   state_nxt = pidaw_pkg::ST_I2_RES;
      pidaw_pkg::ST_I2_RES:   state_nxt = pidaw_pkg::ST_D_SUB;
      pidaw_pkg::ST_D_SUB:    state_nxt = pidaw_pkg::ST_DIV;
      pidaw_pkg::ST_DIV:
        if (div_cnt_r == DIV_LAST) state_nxt = pidaw_pkg::ST_D_QUO;
      pidaw_pkg::ST_D_QUO:
        state_nxt = norm ? pidaw_pkg::ST_DN_MUL : pidaw_pkg::ST_DG_MUL;
      pidaw_pkg::ST_DN_MUL:   state_nxt = pidaw_pkg::ST_DN_RES;
      pidaw_pkg::ST_DN_RES:   state_nxt = pidaw_pkg::ST_DG_MUL;
      pidaw_pkg::ST_DG_MUL:   state_nxt = pidaw_pkg::ST_DG_RES;
      pidaw_pkg::ST_DG_RES:   state_nxt = pidaw_pkg::ST_SUM;
      pidaw_pkg::ST_SUM:      state_nxt = pidaw_pkg::ST_DONE;
      pidaw_pkg::ST_DONE:     if (out_free) state_nxt = pidaw_pkg::ST_IDLE;
      default:                state_nxt = pidaw_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = gain_d_r;
    mul_b = der_r;
    unique case (state_r)
      pidaw_pkg::ST_NORM_MUL: begin
        mul_a = raw_r;
        mul_b = $signed({1'b0, err_scale_r});
      end
      pidaw_pkg::ST_P_MUL: begin
        mul_a = gain_p_r;
        mul_b = err_r;
      end
      pidaw_pkg::ST_I1_MUL: begin
        mul_a = gain_i_r;
        mul_b = err_r;
      end
      pidaw_pkg::ST_I2_MUL: begin
        mul_a = gi_err_r;
        mul_b = $signed({1'b0, item_r.step_time});
      end
      pidaw_pkg::ST_DN_MUL: begin
        mul_a = der_r;
        mul_b = $signed({1'b0, on_meas ? der_scale_r : err_scale_r});
      end
      default: ;
    endcase
  end

  // floor(a*b / 2^FRAC_BITS), saturated
  logic signed [31:0] mulq;
  assign mulq = sat32(prod_r >>> FRAC_BITS);

  // separation test on the current error
  logic signed [32:0] err_mag;
  assign err_mag   = err_r[31] ? -33'(err_r) : 33'(err_r);
  assign integ_nxt = err_mag < $signed({2'b00, sep_thresh_r});

  // integral update with conditional anti-windup
  logic signed [31:0] aw_before, isum_add;
  logic               aw_hold;
  assign aw_before = sat32(64'(p_r) + 64'(isum_r));
  assign aw_hold   = aw_en && (((aw_before >= OUT_MAX_32) && !err_r[31] && (err_r != '0))
                               || ((aw_before <= OUT_MIN_32) && err_r[31]));
  assign isum_add  = aw_hold ? isum_r : sat32(64'(isum_r) + 64'(mulq));

  // derivative difference
  logic signed [31:0] diff;
  logic [31:0]        diff_mag;
  assign diff = on_meas ? sat32(64'(item_r.measured) - 64'(pm_r))
                        : sat32(64'(raw_r) - 64'(pe_r));
  assign diff_mag = diff[31] ? 32'(-diff) : diff;

  // restoring divider step
  logic [31:0] rem_sh;
  logic        div_ge;
  logic [31:0] rem_sub;
  assign rem_sh  = {div_rem_r, div_q_r[DW-1]};
  assign div_ge  = rem_sh >= {1'b0, item_r.step_time};
  assign rem_sub = rem_sh - {1'b0, item_r.step_time};

  logic signed [63:0] quo_s;
  assign quo_s = div_neg_r ? -$signed(64'(div_q_r)) : $signed(64'(div_q_r));

  logic signed [33:0] total;
  assign total = 34'(p_r) + 34'(isum_r) + 34'(d_r);

  // state-held values
  always_comb begin
    isum_nxt = isum_r;
    pm_nxt   = pm_r;
    pe_nxt   = pe_r;
    last_nxt = last_r;
    held_nxt = held_r;
    flag_nxt = integ_r;
    unique case (state_r)
      pidaw_pkg::ST_START: begin
        held_nxt = 1'b0;
        flag_nxt = 1'b0;
        priority if (item_r.kind == pidaw_pkg::KIND_CLEAR) begin
          isum_nxt = '0;
          pm_nxt   = '0;
          pe_nxt   = '0;
          last_nxt = '0;
        end else if (item_r.kind == pidaw_pkg::KIND_PRESET) begin
          isum_nxt = clamp_sym(item_r.integral_preset, int_limit_r);
        end else if (item_r.kind == pidaw_pkg::KIND_UPDATE) begin
          held_nxt = (item_r.step_time == '0);
        end else begin
          held_nxt = 1'b0;
        end
      end
      pidaw_pkg::ST_P_RES:  flag_nxt = integ_nxt;
      pidaw_pkg::ST_I2_RES: isum_nxt = clamp_sym(isum_add, int_limit_r);
      pidaw_pkg::ST_D_SUB: begin
        if (on_meas) pm_nxt = item_r.measured;
        else pe_nxt = raw_r;
      end
      pidaw_pkg::ST_SUM: begin
        if (total > OUT_MAX_S) last_nxt = OUT_MAX_S[16:0];
        else if (total < OUT_MIN_S) last_nxt = OUT_MIN_S[16:0];
        else last_nxt = total[16:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidaw_pkg::ST_IDLE;
      isum_r      <= '0;
      pm_r        <= '0;
      pe_r        <= '0;
      last_r      <= '0;
      held_r      <= 1'b0;
      integ_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      isum_r  <= isum_nxt;
      pm_r    <= pm_nxt;
      pe_r    <= pe_nxt;
      last_r  <= last_nxt;
      held_r  <= held_nxt;
      integ_r <= flag_nxt;
      if (state_r == pidaw_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (in_fire) item_r <= in_data;
    if (state_r == pidaw_pkg::ST_DONE && out_free) begin
      out_data_r.control_output <= last_r;
      out_data_r.integrating    <= integ_r;
      out_data_r.held           <= held_r;
    end
    unique case (state_r)
      pidaw_pkg::ST_START: begin
        raw_r <= sat32(64'(item_r.target) - 64'(item_r.measured));
        err_r <= sat32(64'(item_r.target) - 64'(item_r.measured));
      end
      pidaw_pkg::ST_NORM_RES: err_r <= clamp_sym(mulq, ONE_Q);
      pidaw_pkg::ST_P_RES:    p_r <= mulq;
      pidaw_pkg::ST_I1_RES:   gi_err_r <= mulq;
      pidaw_pkg::ST_D_SUB: begin
        div_q_r   <= {diff_mag, FRAC_BITS'(0)};
        div_rem_r <= '0;
        div_cnt_r <= '0;
        div_neg_r <= diff[31];
      end
      pidaw_pkg::ST_DIV: begin
        div_q_r   <= {div_q_r[DW-2:0], div_ge};
        div_rem_r <= div_ge ? rem_sub[30:0] : rem_sh[30:0];
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      pidaw_pkg::ST_D_QUO:  der_r <= sat32(quo_s);
      pidaw_pkg::ST_DN_RES: der_r <= clamp_sym(mulq, ONE_Q);
      pidaw_pkg::ST_DG_RES: d_r <= on_meas ? sat32(-64'(mulq)) : mulq;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/pidaw_checker.sv
module pidaw_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input pidaw_pkg::pidaw_in_t                 in_data,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input pidaw_pkg::pidaw_out_t                out_data
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block takes one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new transfer accepted while busy");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.control_output <= 17'(pidaw_pkg::OUT_MAX_Q_DEF))
    else $error("drive value above full scale");

  // A held step never integrates.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.held && out_data.integrating))
    else $error("held and integrating both set");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/pid_checker.sv
`timescale 1ns / 1ps

module pid_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  pidaw_pkg::pidaw_in_t             in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  pidaw_pkg::pidaw_out_t            out_data,
  input  logic                             cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending
);

  localparam longint ONE = 64'sd1 << pidaw_pkg::FRAC_BITS_DEF;
  localparam longint OMAX = pidaw_pkg::OUT_MAX_Q_DEF;
  localparam longint OMIN = pidaw_pkg::OUT_MIN_Q_DEF;

  longint kp, ki, kd, escale, dscale, sep_thr, ilim;
  logic [2:0] ctl_mode;
  longint isum, prev_meas, prev_err, drive;
  pidaw_pkg::pidaw_out_t drive_q[$];

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Product floored to minus infinity; >>> on a signed longint floors.
  function automatic longint qmul(longint a, longint b);
    return sat((a * b) >>> pidaw_pkg::FRAC_BITS_DEF);
  endfunction

  function automatic longint qrate(longint d, longint t);
    return sat((d * ONE) / t);
  endfunction

  function automatic pidaw_pkg::pidaw_out_t next_drive(pidaw_pkg::pidaw_in_t it);
    pidaw_pkg::pidaw_out_t r;
    longint m, t, st, raw, e, p, iv, der, dt, delta, pre;
    logic integ, add;
    m = longint'(it.measured);
    t = longint'(it.target);
    st = longint'({1'b0, it.step_time});
    r = '0;
    if (it.kind == pidaw_pkg::KIND_CLEAR) begin
      isum = 0; prev_meas = 0; prev_err = 0; drive = 0;
    end else if (it.kind == pidaw_pkg::KIND_PRESET) begin
      isum = clip(longint'(it.integral_preset), ilim);
    end else if (it.kind == pidaw_pkg::KIND_UPDATE) begin
      if (st == 0) begin
        r.held = 1'b1;
      end else begin
        raw = sat(t - m);
        e = raw;
        if (ctl_mode[pidaw_pkg::MODE_NORM]) e = clip(qmul(raw, escale), ONE);
        p = qmul(kp, e);
        iv = isum;
        integ = ((e < 0) ? -e : e) < sep_thr;
        if (integ) begin
          delta = qmul(qmul(ki, e), st);
          add = 1'b1;
          if (ctl_mode[pidaw_pkg::MODE_AW]) begin
            pre = sat(p + isum);
            add = !((pre >= OMAX && e > 0) || (pre <= OMIN && e < 0));
          end
          if (add) isum = sat(isum + delta);
          isum = clip(isum, ilim);
          iv = isum;
        end
        if (ctl_mode[pidaw_pkg::MODE_ON_MEAS]) begin
          der = qrate(sat(m - prev_meas), st);
          if (ctl_mode[pidaw_pkg::MODE_NORM]) der = clip(qmul(der, dscale), ONE);
          dt = sat(-qmul(kd, der));
          prev_meas = m;
        end else begin
          der = qrate(sat(raw - prev_err), st);
          if (ctl_mode[pidaw_pkg::MODE_NORM]) der = clip(qmul(der, escale), ONE);
          dt = qmul(kd, der);
          prev_err = raw;
        end
        pre = p + iv + dt;
        if (pre > OMAX) pre = OMAX;
        if (pre < OMIN) pre = OMIN;
        drive = pre;
        r.integrating = integ;
      end
    end
    r.control_output = drive[pidaw_pkg::OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pidaw_pkg::pidaw_out_t want;
    if (!rst_n) begin
      kp <= 0; ki <= 0; kd <= 0;
      escale <= 65536; dscale <= 65536; sep_thr <= 64'sd2147483647; ilim <= 0;
      ctl_mode <= '0;
      isum = 0; prev_meas = 0; prev_err = 0; drive = 0;
      drive_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pidaw_pkg::CFG_GAIN_P:     kp <= longint'(signed'(cfg_data));
          pidaw_pkg::CFG_GAIN_I:     ki <= longint'(signed'(cfg_data));
          pidaw_pkg::CFG_GAIN_D:     kd <= longint'(signed'(cfg_data));
          pidaw_pkg::CFG_ERR_SCALE:  escale <= longint'({1'b0, cfg_data[30:0]});
          pidaw_pkg::CFG_DER_SCALE:  dscale <= longint'({1'b0, cfg_data[30:0]});
          pidaw_pkg::CFG_SEP_THRESH: sep_thr <= longint'({1'b0, cfg_data[30:0]});
          pidaw_pkg::CFG_INT_LIMIT:  ilim <= longint'({1'b0, cfg_data[30:0]});
          pidaw_pkg::CFG_MODE:       ctl_mode <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) drive_q.push_back(next_drive(in_data));
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = drive_q.pop_front();
          if (want.control_output !== out_data.control_output ||
              want.integrating !== out_data.integrating ||
              want.held !== out_data.held) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= drive_q.size();
    end
  end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pidaw_pkg::pidaw_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pidaw_pkg::pidaw_out_t out_data;
  logic cfg_we = 1'b0;
  logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pidaw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 0, stall_pct = 0;
  int hold_req = 0, hold_done = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pid_controller_antiwindup dut (.*);

  pid_checker chk (.*);

  // Receiver: random stalls, or a long hold-off counted here.
  always @(posedge clk) begin
    int n;
    if (hold_req != hold_done) begin
      out_stall <= 1'b1;
      for (n = 0; n < 400; n++) @(posedge clk);
      out_stall <= 1'b0;
      hold_done <= hold_req;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [pidaw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (n = 0; n < 100; n++) @(posedge clk);
  endtask

  task automatic send(input pidaw_pkg::pidaw_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(262144) - 131072;
    endcase
  endfunction

  function automatic pidaw_pkg::pidaw_in_t rand_item();
    pidaw_pkg::pidaw_in_t it;
    int k;
    k = $urandom_range(19);
    it.kind = (k == 0) ? pidaw_pkg::KIND_CLEAR : (k == 1) ? pidaw_pkg::KIND_PRESET :
              (k == 2) ? 2'd3 : pidaw_pkg::KIND_UPDATE;
    it.measured = rand_val();
    it.target = rand_val();
    case ($urandom_range(7))
      0: it.step_time = '0;
      1: it.step_time = 31'($urandom);
      2: it.step_time = 31'h7fffffff;
      default: it.step_time = 31'($urandom_range(131072, 1));
    endcase
    it.integral_preset = rand_val();
    return it;
  endfunction

  task automatic random_config(input int sel);
    logic [31:0] v[8];
    int i;
    for (i = 0; i < 8; i++) v[i] = rand_val();
    if (sel == 0) begin
      v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'd7};
    end else if (sel == 1) begin
      v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    end else begin
      v[3] = $urandom_range(196608);
      v[4] = $urandom_range(196608);
      v[5] = ($urandom_range(3) == 0) ? 32'h7fffffff : $urandom_range(262144);
      v[6] = $urandom_range(3) == 0 ? $urandom : $urandom_range(131072);
      v[7] = $urandom_range(7);
      if ($urandom_range(1)) v[0] = $urandom_range(131072) - 32768;
      if ($urandom_range(1)) v[1] = $urandom_range(131072) - 32768;
      if ($urandom_range(1)) v[2] = $urandom_range(131072) - 32768;
    end
    for (i = 0; i < 8; i++) write_reg(pidaw_pkg::CFG_IDX_W'(i), v[i]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    pidaw_pkg::pidaw_in_t it;
    int ph, i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed items at reset settings, then with all gains and modes set.
    for (ph = 0; ph < 2; ph++) begin
      if (ph == 1) random_config(0);
      it = '{pidaw_pkg::KIND_UPDATE, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 32'h0};
      send(it);
      it = '{pidaw_pkg::KIND_UPDATE, 32'h7fffffff, 32'h80000000, 31'd1, 32'h0};
      send(it);
      it = '{pidaw_pkg::KIND_UPDATE, 32'd5, 32'd9, 31'd0, 32'h0};
      send(it);
      it = '{pidaw_pkg::KIND_PRESET, 32'd0, 32'd0, 31'd1, 32'h7fffffff};
      send(it);
      it = '{pidaw_pkg::KIND_PRESET, 32'd0, 32'd0, 31'd1, 32'h80000000};
      send(it);
      it = '{pidaw_pkg::KIND_UPDATE, 32'hffff0000, 32'h00010000, 31'h10000, 32'h0};
      send(it);
      it = '{2'd3, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 32'hffffffff};
      send(it);
      it = '{pidaw_pkg::KIND_CLEAR, 32'd0, 32'd0, 31'd0, 32'd0};
      send(it);
      it = '{pidaw_pkg::KIND_UPDATE, 32'd0, 32'd100, 31'd655, 32'h0};
      send(it);
      drain();
    end
    for (ph = 0; ph < 16; ph++) begin
      random_config(ph == 15 ? 1 : 2);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      if (ph == 5) hold_req <= hold_req + 1;
      for (i = 0; i < 100; i++) begin
        send(rand_item());
        // Pause here until everything in flight has come back.
        if (ph == 3 && i == 50) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: files.f
rtl/core/pidaw_pkg.sv
rtl/core/pid_controller_antiwindup.sv
rtl/core/pidaw_checker.sv
sim/pid_checker.sv
sim/tb.sv
